>>> design/scf_pkg.sv
// Shared constants, types and helpers of the sentence checksum framer.
// Used by the channel interfaces, the top level and its checker; no dependencies.
`default_nettype none

package scf_pkg;

   localparam int unsigned DEFAULT_LENGTH_LIMIT = 4095;

   localparam int unsigned TAG_WIDTH = 48;
   localparam int unsigned LEN_WIDTH = 12;
   localparam int unsigned PREFIX_BYTES = 6;

   localparam logic [TAG_WIDTH-1:0] NAV_TAG_RESET = 48'h2447_5046_5044;
   localparam logic [TAG_WIDTH-1:0] IMU_TAG_RESET = 48'h2447_544D_5455;

   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   localparam logic [0:0] REG_NAV_TAG = 1'b0;
   localparam logic [0:0] REG_IMU_TAG = 1'b1;

   localparam logic [1:0] TYPE_OTHER = 2'd0;
   localparam logic [1:0] TYPE_NAV   = 2'd1;
   localparam logic [1:0] TYPE_IMU   = 2'd2;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type d;
      d.ok    = 1'b1;
      d.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.value = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.value = 4'(b - 8'h37);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.value = 4'(b - 8'h57);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

>>> design/scf_channels.sv
// Valid/ready channel interfaces of the sentence checksum framer.
// Depends on scf_pkg for the field widths.
`default_nettype none

interface scf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface scf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           line_valid;
   logic [1:0]                     sentence_type;
   logic [7:0]                     computed_sum;
   logic [7:0]                     received_sum;
   logic [scf_pkg::LEN_WIDTH-1:0]  line_length;
   logic                           length_overflow;

   modport source (output valid, output line_valid, output sentence_type,
                   output computed_sum, output received_sum, output line_length,
                   output length_overflow, input ready);
   modport sink (input valid, input line_valid, input sentence_type,
                 input computed_sum, input received_sum, input line_length,
                 input length_overflow, output ready);
endinterface

interface scf_csr_if;
   logic                           valid;
   logic                           ready;
   logic [0:0]                     reg_index;
   logic [scf_pkg::TAG_WIDTH-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

>>> design/sentence_checksum_framer.sv
// Sentence checksum framer: splits a byte stream into CR LF lines and checks each line.
// The LF byte is held in the input register; the result registers load when it advances.
// Throughput: one byte request per cycle; a stalled result stalls intake behind one buffered byte.
// Reset (synchronous, active high) clears the line state and restores both tag registers.
// Depends on scf_pkg and the channel interfaces in scf_channels.sv.
`default_nettype none

module sentence_checksum_framer #(
   parameter int unsigned LENGTH_LIMIT = scf_pkg::DEFAULT_LENGTH_LIMIT
) (
   input  wire        clock,
   input  wire        reset,
   scf_req_if.sink    req_chan,
   scf_rsp_if.source  rsp_chan,
   scf_csr_if.sink    csr_chan
);

   localparam int unsigned CW = $clog2(LENGTH_LIMIT + 1);

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_SUM   = 3'd1;
   localparam logic [2:0] PH_DIG1  = 3'd2;
   localparam logic [2:0] PH_DIG2  = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;
   localparam logic [2:0] PH_SKIP  = 3'd5;

   typedef struct packed {
      logic [2:0]                      phase;
      logic [7:0]                      xor_sum;
      logic [7:0]                      digits;
      logic [scf_pkg::TAG_WIDTH-1:0]   prefix;
      logic [CW-1:0]                   count;
      logic                            hex1;
      logic                            over;
   } line_state_type;

   localparam line_state_type LINE_CLEAR = '{
      phase: PH_START, xor_sum: 8'd0, digits: 8'd0, prefix: '0,
      count: '0, hex1: 1'b0, over: 1'b0};

   function automatic line_state_type take_byte(input line_state_type s,
                                                input logic [7:0] b);
      line_state_type       n;
      scf_pkg::hex_digit_type d;
      n = s;
      d = scf_pkg::hex_decode(b);
      if (s.count < CW'(scf_pkg::PREFIX_BYTES)) begin
         n.prefix = {s.prefix[scf_pkg::TAG_WIDTH-9:0], b};
      end
      if (s.count >= CW'(LENGTH_LIMIT)) begin
         n.over = 1'b1;
      end else begin
         n.count = s.count + CW'(1);
      end
      unique case (s.phase)
         PH_START: begin
            n.phase = (b == scf_pkg::CH_DOLLAR) ? PH_SUM : PH_SKIP;
         end
         PH_SUM: begin
            if (b == scf_pkg::CH_STAR) begin
               n.phase = PH_DIG1;
            end else begin
               n.xor_sum = s.xor_sum ^ b;
            end
         end
         PH_DIG1: begin
            if (d.ok) begin
               n.digits = {4'd0, d.value};
               n.hex1   = 1'b1;
               n.phase  = PH_DIG2;
            end else begin
               n.phase = PH_DONE;
            end
         end
         PH_DIG2: begin
            if (d.ok) begin
               n.digits = {s.digits[3:0], d.value};
            end
            n.phase = PH_DONE;
         end
         default: begin
            n.phase = s.phase;
         end
      endcase
      return n;
   endfunction

   logic [scf_pkg::TAG_WIDTH-1:0] nav_tag_ff, nav_tag_in;
   logic [scf_pkg::TAG_WIDTH-1:0] imu_tag_ff, imu_tag_in;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   line_state_type line_ff, line_in;
   logic           cr_ff, cr_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           line_valid_ff, line_valid_in;
   logic [1:0]                     type_ff, type_in;
   logic [7:0]                     computed_ff, computed_in;
   logic [7:0]                     received_ff, received_in;
   logic [scf_pkg::LEN_WIDTH-1:0]  length_ff, length_in;
   logic                           overflow_ff, overflow_in;

   logic           advance;
   logic           emit;
   line_state_type after_cr;
   line_state_type after_byte;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign emit    = advance && cr_ff && (in_byte_ff == scf_pkg::CH_LF);

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      nav_tag_in = nav_tag_ff;
      imu_tag_in = imu_tag_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            scf_pkg::REG_NAV_TAG: nav_tag_in = csr_chan.write_data;
            scf_pkg::REG_IMU_TAG: imu_tag_in = csr_chan.write_data;
            default: begin
               nav_tag_in = nav_tag_ff;
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.data_byte;
      end
   end

   // A pending CR that is not followed by LF is line content ahead of this byte.
   always_comb begin
      after_cr   = cr_ff ? take_byte(line_ff, scf_pkg::CH_CR) : line_ff;
      after_byte = (in_byte_ff == scf_pkg::CH_CR) ? after_cr : take_byte(after_cr, in_byte_ff);
      line_in    = line_ff;
      cr_in      = cr_ff;
      if (emit) begin
         line_in = LINE_CLEAR;
         cr_in   = 1'b0;
      end else if (advance) begin
         line_in = after_byte;
         cr_in   = (in_byte_ff == scf_pkg::CH_CR);
      end
   end

   always_comb begin
      line_valid_in = (line_ff.phase == PH_DONE) && line_ff.hex1 &&
                      (line_ff.xor_sum == line_ff.digits);
      type_in = scf_pkg::TYPE_OTHER;
      if (line_ff.count >= CW'(scf_pkg::PREFIX_BYTES)) begin
         if (line_ff.prefix == nav_tag_ff) begin
            type_in = scf_pkg::TYPE_NAV;
         end else if (line_ff.prefix == imu_tag_ff) begin
            type_in = scf_pkg::TYPE_IMU;
         end
      end
      computed_in = line_ff.xor_sum;
      received_in = line_ff.digits;
      if (32'(line_ff.count) > 32'(scf_pkg::LEN_MAX)) begin
         length_in = scf_pkg::LEN_MAX;
      end else begin
         length_in = scf_pkg::LEN_WIDTH'(line_ff.count);
      end
      overflow_in = line_ff.over;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nav_tag_ff   <= scf_pkg::NAV_TAG_RESET;
         imu_tag_ff   <= scf_pkg::IMU_TAG_RESET;
         in_valid_ff  <= 1'b0;
         line_ff      <= LINE_CLEAR;
         cr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nav_tag_ff   <= nav_tag_in;
         imu_tag_ff   <= imu_tag_in;
         in_valid_ff  <= in_valid_in;
         line_ff      <= line_in;
         cr_ff        <= cr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (emit) begin
         line_valid_ff <= line_valid_in;
         type_ff       <= type_in;
         computed_ff   <= computed_in;
         received_ff   <= received_in;
         length_ff     <= length_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.line_valid      = line_valid_ff;
   assign rsp_chan.sentence_type   = type_ff;
   assign rsp_chan.computed_sum    = computed_ff;
   assign rsp_chan.received_sum    = received_ff;
   assign rsp_chan.line_length     = length_ff;
   assign rsp_chan.length_overflow = overflow_ff;

endmodule

`default_nettype wire

>>> design/scf_checker.sv
// Port-level checker of the sentence checksum framer, bound to its top level.
// Depends on scf_pkg and the channel interfaces in scf_channels.sv.
`default_nettype none

module scf_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire                           line_valid,
   input wire [1:0]                     sentence_type,
   input wire [7:0]                     computed_sum,
   input wire [7:0]                     received_sum,
   input wire [scf_pkg::LEN_WIDTH-1:0]  line_length,
   input wire                           length_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(computed_sum) &&
      $stable(received_sum) && $stable(line_length))
      else $error("Stalled result changed or dropped.");

   a_valid_sums: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && line_valid |-> computed_sum == received_sum)
      else $error("Line marked valid with mismatched checksums.");

   a_overflow_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && length_overflow |-> line_length != '0)
      else $error("Overflowed line reports zero length.");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> sentence_type == scf_pkg::TYPE_OTHER ||
      sentence_type == scf_pkg::TYPE_NAV || sentence_type == scf_pkg::TYPE_IMU)
      else $error("Sentence type out of range.");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

endmodule

bind sentence_checksum_framer scf_checker u_scf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .line_valid      (rsp_chan.line_valid),
   .sentence_type   (rsp_chan.sentence_type),
   .computed_sum    (rsp_chan.computed_sum),
   .received_sum    (rsp_chan.received_sum),
   .line_length     (rsp_chan.line_length),
   .length_overflow (rsp_chan.length_overflow)
);

`default_nettype wire

>>> sim/tb_sentence_checksum_framer.sv
// Self-checking testbench of the sentence checksum framer: directed and random byte streams.
// Depends on scf_pkg, the channel interfaces in scf_channels.sv and the framer top level.
`default_nettype none

module tb_sentence_checksum_framer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_LIMIT = scf_pkg::DEFAULT_LENGTH_LIMIT;
   localparam int RANDOM_BYTES = 650;

   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_SUM,
      SCAN_DIG1,
      SCAN_DIG2,
      SCAN_DONE,
      SCAN_SKIP
   } scan_phase_type;

   typedef struct packed {
      logic                          line_valid;
      logic [1:0]                    sentence_type;
      logic [7:0]                    computed_sum;
      logic [7:0]                    received_sum;
      logic [scf_pkg::LEN_WIDTH-1:0] line_length;
      logic                          length_overflow;
   } line_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scf_req_if req_chan();
   scf_rsp_if rsp_chan();
   scf_csr_if csr_chan();

   sentence_checksum_framer #(
      .LENGTH_LIMIT(LINE_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   line_report_type               pending_reports[$];
   logic [7:0]                    line_bytes[$];
   int                            line_start = 0;
   logic [scf_pkg::TAG_WIDTH-1:0] nav_tag_shadow;
   logic [scf_pkg::TAG_WIDTH-1:0] imu_tag_shadow;
   scan_phase_type                scan_phase;
   logic [7:0]                    line_xor;
   logic [7:0]                    line_digits;
   logic                          cr_held;
   logic [scf_pkg::TAG_WIDTH-1:0] prefix_bytes;
   int                            line_count;
   logic                          hex1_seen;
   logic                          over_limit;
   int                            bytes_sent = 0;
   int                            error_count = 0;
   bit                            idle_enable = 1'b1;
   int                            rsp_hold = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - 48;
      if (b >= "A" && b <= "F") return int'(b) - 55;
      if (b >= "a" && b <= "f") return int'(b) - 87;
      return -1;
   endfunction

   function automatic void clear_line_state();
      scan_phase   = SCAN_START;
      line_xor     = 8'h00;
      line_digits  = 8'h00;
      cr_held      = 1'b0;
      prefix_bytes = '0;
      line_count   = 0;
      hex1_seen    = 1'b0;
      over_limit   = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b);
      int v;
      if (line_count < scf_pkg::PREFIX_BYTES) begin
         prefix_bytes = {prefix_bytes[scf_pkg::TAG_WIDTH-9:0], b};
      end
      if (line_count >= LINE_LIMIT) over_limit = 1'b1;
      else line_count++;
      case (scan_phase)
         SCAN_START: begin
            scan_phase = (b == scf_pkg::CH_DOLLAR) ? SCAN_SUM : SCAN_SKIP;
         end
         SCAN_SUM: begin
            if (b == scf_pkg::CH_STAR) scan_phase = SCAN_DIG1;
            else line_xor ^= b;
         end
         SCAN_DIG1: begin
            v = hex_nibble(b);
            if (v >= 0) begin
               line_digits = 8'(v);
               hex1_seen = 1'b1;
               scan_phase = SCAN_DIG2;
            end else begin
               scan_phase = SCAN_DONE;
            end
         end
         SCAN_DIG2: begin
            v = hex_nibble(b);
            if (v >= 0) line_digits = {line_digits[3:0], 4'(v)};
            scan_phase = SCAN_DONE;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void close_line();
      line_report_type r;
      r.line_valid = (scan_phase == SCAN_DONE) && hex1_seen && (line_xor == line_digits);
      r.sentence_type = scf_pkg::TYPE_OTHER;
      if (line_count >= scf_pkg::PREFIX_BYTES || over_limit) begin
         if (prefix_bytes == nav_tag_shadow) r.sentence_type = scf_pkg::TYPE_NAV;
         else if (prefix_bytes == imu_tag_shadow) r.sentence_type = scf_pkg::TYPE_IMU;
      end
      r.computed_sum = line_xor;
      r.received_sum = line_digits;
      r.line_length = (line_count > int'(scf_pkg::LEN_MAX)) ? scf_pkg::LEN_MAX :
                      line_count[scf_pkg::LEN_WIDTH-1:0];
      r.length_overflow = over_limit;
      pending_reports.insert(pending_reports.size(), r);
   endfunction

   function automatic void frame_byte(input logic [7:0] b);
      if (cr_held) begin
         if (b == scf_pkg::CH_LF) begin
            close_line();
            clear_line_state();
            return;
         end
         cr_held = 1'b0;
         scan_byte(scf_pkg::CH_CR);
      end
      if (b == scf_pkg::CH_CR) cr_held = 1'b1;
      else scan_byte(b);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] content_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == scf_pkg::CH_STAR || b == scf_pkg::CH_CR || b == scf_pkg::CH_LF);
      return b;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (hex_nibble(b) >= 0 || b == scf_pkg::CH_CR || b == scf_pkg::CH_LF);
      return b;
   endfunction

   function automatic logic [scf_pkg::TAG_WIDTH-1:0] random_tag();
      logic [scf_pkg::TAG_WIDTH-1:0] t;
      t[47:40] = scf_pkg::CH_DOLLAR;
      for (int i = 0; i < 5; i++) t[i*8 +: 8] = 8'($urandom_range(8'h41, 8'h5A));
      return t;
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      line_bytes.insert(line_bytes.size(), b);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_tag(input logic [scf_pkg::TAG_WIDTH-1:0] t);
      for (int i = 5; i >= 0; i--) put_byte(t[i*8 +: 8]);
   endfunction

   function automatic void put_crlf();
      put_byte(scf_pkg::CH_CR);
      put_byte(scf_pkg::CH_LF);
      line_start = line_bytes.size();
   endfunction

   function automatic void put_checksum(input int digits, input bit lower, input bit corrupt);
      logic [7:0] sum;
      sum = 8'h00;
      for (int i = line_start + 1; i < line_bytes.size(); i++) sum ^= line_bytes[i];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      put_byte(scf_pkg::CH_STAR);
      if (digits >= 2) begin
         put_byte(hex_char(sum[7:4], lower));
         put_byte(hex_char(sum[3:0], lower));
      end else begin
         put_byte(hex_char(sum[3:0], lower));
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      do @(posedge clock);
      while (req_chan.ready !== 1'b1);
      frame_byte(b);
      bytes_sent++;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_queued();
      for (int i = 0; i < line_bytes.size(); i++) send_byte(line_bytes[i]);
      line_bytes.delete();
      line_start = 0;
   endtask

   task automatic settle_lines();
      req_chan.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_tags(input logic [scf_pkg::TAG_WIDTH-1:0] nav,
                            input logic [scf_pkg::TAG_WIDTH-1:0] imu);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= scf_pkg::REG_NAV_TAG;
      csr_chan.write_data <= nav;
      do @(posedge clock);
      while (csr_chan.ready !== 1'b1);
      csr_chan.reg_index <= scf_pkg::REG_IMU_TAG;
      csr_chan.write_data <= imu;
      do @(posedge clock);
      while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      nav_tag_shadow = nav;
      imu_tag_shadow = imu;
   endtask

   task automatic test_checksum_cases();
      put_text("$GPFPD,123.4,A"); put_checksum(2, 0, 0); put_crlf();
      put_text("$GTIMU,9,-1"); put_checksum(2, 1, 0); put_crlf();
      put_text("$GPGGA,1"); put_checksum(2, 0, 1); put_crlf();
      put_text("$*00"); put_crlf();
      put_text("GPFPD,1*00"); put_crlf();
      put_text("$NOSTAR,7"); put_crlf();
      put_text("$AB*G1"); put_crlf();
      put_text("$AB* 1"); put_crlf();
      put_text("$AB*-3"); put_crlf();
      put_text("$"); put_byte(8'h04); put_text("*4Z"); put_crlf();
      put_text("$AB"); put_checksum(1, 0, 0); put_crlf();
      put_text("$A"); put_byte(scf_pkg::CH_CR); put_text("B");
      put_checksum(2, 0, 0); put_crlf();
      put_text("$A"); put_byte(scf_pkg::CH_LF); put_text("B");
      put_checksum(2, 0, 0); put_crlf();
      put_text("$XY"); put_checksum(2, 0, 0); put_text("7*$*q"); put_crlf();
      put_crlf();
      put_text("$GP"); put_crlf();
      put_text("$GPFPD"); put_crlf();
      put_text("$A*41"); put_byte(scf_pkg::CH_CR); put_crlf();
      put_byte(8'h00); put_byte(8'hFF);
      put_byte(8'h80); put_byte(8'h7F); put_crlf();
      put_text("$"); put_byte(8'hFF); put_byte(8'h00);
      put_checksum(2, 1, 0); put_crlf();
      send_queued();
   endtask

   task automatic test_tag_registers();
      settle_lines();
      load_tags('0, '1);
      repeat (6) put_byte(8'hFF);
      put_crlf();
      repeat (6) put_byte(8'h00);
      put_text("tail"); put_crlf();
      repeat (5) put_byte(8'hFF);
      put_crlf();
      send_queued();
      settle_lines();
      load_tags(48'h2441_4243_4445, 48'h2441_4243_4445);
      put_text("$ABCDE,1"); put_checksum(2, 0, 0); put_crlf();
      put_text("$ABCDF,1"); put_checksum(2, 0, 0); put_crlf();
      send_queued();
      settle_lines();
      load_tags(random_tag(), random_tag());
      put_tag(imu_tag_shadow); put_checksum(2, 0, 0); put_crlf();
      put_tag(nav_tag_shadow); put_text(",x"); put_checksum(2, 1, 1); put_crlf();
      send_queued();
      settle_lines();
      load_tags(scf_pkg::NAV_TAG_RESET, scf_pkg::IMU_TAG_RESET);
   endtask

   task automatic test_long_lines();
      int body_sizes[2];
      body_sizes = '{256, 517};
      foreach (body_sizes[k]) begin
         put_byte(scf_pkg::CH_DOLLAR);
         repeat (body_sizes[k]) put_byte(content_byte());
         put_checksum(2, 0, k == 1);
         put_crlf();
         send_queued();
      end
      put_text("GTIMU");
      repeat (40) put_byte(8'($urandom_range(8'h20, 8'h7E)));
      put_crlf();
      send_queued();
   endtask

   task automatic test_random_traffic();
      int stop_at;
      int retag_at;
      int kind;
      stop_at = bytes_sent + RANDOM_BYTES;
      retag_at = bytes_sent + 200;
      while (bytes_sent < stop_at) begin
         if (bytes_sent >= retag_at) begin
            settle_lines();
            load_tags(random_tag(), random_tag());
            retag_at = bytes_sent + 200;
         end
         if (stop_at - bytes_sent < 150) idle_enable = 1'b0;
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            case ($urandom_range(0, 2))
               0: put_tag(nav_tag_shadow);
               1: put_tag(imu_tag_shadow);
               default: put_byte(scf_pkg::CH_DOLLAR);
            endcase
            repeat ($urandom_range(0, 20)) put_byte(content_byte());
            put_checksum(($urandom_range(0, 5) == 0) ? 1 : 2, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) put_text("*$9");
            put_crlf();
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
            put_crlf();
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 12)) begin
               case ($urandom_range(0, 4))
                  0: put_byte(scf_pkg::CH_CR);
                  1: put_byte(scf_pkg::CH_LF);
                  2: put_byte(scf_pkg::CH_STAR);
                  3: put_byte(scf_pkg::CH_DOLLAR);
                  default: put_byte(8'($urandom));
               endcase
            end
         end else begin
            put_byte(scf_pkg::CH_DOLLAR);
            repeat ($urandom_range(0, 10)) put_byte(content_byte());
            put_byte(scf_pkg::CH_STAR);
            put_byte(non_hex_byte());
            put_byte(content_byte());
            put_crlf();
         end
         send_queued();
      end
   endtask

   task automatic compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      line_report_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none actual sum %h length %0d",
                     $time, rsp_chan.computed_sum, rsp_chan.line_length);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("line_valid", 12'(want.line_valid), 12'(rsp_chan.line_valid));
            compare_field("sentence_type", 12'(want.sentence_type),
                          12'(rsp_chan.sentence_type));
            compare_field("computed_sum", 12'(want.computed_sum), 12'(rsp_chan.computed_sum));
            compare_field("received_sum", 12'(want.received_sum), 12'(rsp_chan.received_sum));
            compare_field("line_length", want.line_length, rsp_chan.line_length);
            compare_field("length_overflow", 12'(want.length_overflow),
                          12'(rsp_chan.length_overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_hold <= $urandom_range(0, 4);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= 8'h00;
      csr_chan.valid <= 1'b0;
      csr_chan.reg_index <= scf_pkg::REG_NAV_TAG;
      csr_chan.write_data <= '0;
      nav_tag_shadow = scf_pkg::NAV_TAG_RESET;
      imu_tag_shadow = scf_pkg::IMU_TAG_RESET;
      clear_line_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_checksum_cases();
      test_tag_registers();
      test_long_lines();
      test_random_traffic();
      settle_lines();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
